// File: src/gf2m_pkg.sv
// Shared types and constants for the GF(2^m) arithmetic unit.
// Holds the beat structs, the operation codes and the register indexes.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package gf2m_pkg;

    // Fixed widths of the fields on the ports.
    localparam int ELEM_W     = 8;
    localparam int DEG_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Lowest degree the unit works with; smaller register values are raised to it.
    localparam int MIN_DEGREE = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_DEGREE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCTION_POLY = 1'd1;

    // Register values after reset: x^8 + x^4 + x^3 + x + 1.
    localparam logic [DEG_W-1:0]  RESET_DEGREE = 4'd8;
    localparam logic [ELEM_W-1:0] RESET_POLY   = 8'd27;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ELEM_W-1:0] operand_a;
        logic [ELEM_W-1:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic [ELEM_W-1:0] field_result;
        logic              divide_by_zero;
    } out_beat_t;

endpackage

`default_nettype wire

// File: src/gf2m_arith_unit.sv
// Top level of the GF(2^m) arithmetic unit: add, subtract, multiply and divide.
// Bit-serial multiplier and bit-serial extended Euclidean inverter in one datapath.
// Depends on gf2m_pkg for the beat structs, operation codes and register indexes.
//
//   Channel   Direction  Handshake               Beat
//   in        in         in_valid / in_stall     gf2m_pkg::in_beat_t  (kind, operand_a, operand_b)
//   out       out        out_valid / out_stall   gf2m_pkg::out_beat_t (field_result, divide_by_zero)
//   cfg       in         cfg_we, cfg_index       cfg_data (field_degree, reduction_poly)
//
// An accepted add or subtract beat passes from the idle state to the done state, then to the output
// register. Multiply runs the multiplier in between, which consumes one bit of the multiplier
// operand per cycle. Divide first runs the inverter, which takes one shift, one XOR or one
// swap of its remainder registers per cycle, then the multiplier for an invertible divisor.
// Only one beat is worked on at a time; the next input beat is taken once the datapath is
// idle, even while the previous result still waits in the output register.
// A finished result that cannot enter the output register because it is full and stalled
// waits in the datapath. Reset restores degree 8 and modulus 0x11B; there is no clearing pass.
`default_nettype none

module gf2m_arith_unit #(
    parameter int MAX_DEGREE = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire gf2m_pkg::in_beat_t                   in_data,

    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output gf2m_pkg::out_beat_t                       out_data,

    input  wire logic                                 cfg_we,
    input  wire logic [gf2m_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gf2m_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // W is the widest element the datapath handles, DW holds a degree from 0 to W,
    // TW holds a scaled cofactor of the inverter.
    localparam int W  = MAX_DEGREE;
    localparam int DW = $clog2(W + 1);
    localparam int TW = 2 * W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INV,
        S_MUL,
        S_DONE
    } state_t;

    // Configuration registers.
    logic [gf2m_pkg::DEG_W-1:0]  field_degree_reg;
    logic [gf2m_pkg::ELEM_W-1:0] reduction_poly_reg;

    // Control and output registers.
    state_t              state_reg;
    logic                out_valid_reg;
    gf2m_pkg::out_beat_t out_data_reg;

    // Datapath registers. The inverter keeps each remainder left-aligned so that its
    // claimed degree sits at bit W: r = poly * x^(W - d). The cofactor beside it carries
    // the same scale factor, so one remainder step is a plain XOR of both pairs.
    logic [W:0]    r0_reg;
    logic [W:0]    r1_reg;
    logic [TW-1:0] s0_reg;
    logic [TW-1:0] s1_reg;
    logic [DW-1:0] d0_reg;
    logic [DW-1:0] d1_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  mul_a_reg;
    logic [W-1:0]  mul_b_reg;
    logic [DW-1:0] cnt_reg;
    logic          dz_reg;

    // Field derived from the configuration.
    logic [DW-1:0] m_eff;
    logic [W-1:0]  elem_mask;
    logic [W-1:0]  top_mask;
    logic [W-1:0]  poly_low;
    logic [W:0]    modulus;

    // Masked operands and the outgoing element.
    logic [W-1:0]                op_a;
    logic [W-1:0]                op_b;
    logic [gf2m_pkg::ELEM_W-1:0] result_elem;
    logic [gf2m_pkg::ELEM_W-1:0] result_mask;

    // Step logic.
    logic         acc_top;
    logic [W-1:0] acc_step;
    logic         inv_done;
    logic         inv_ok;
    logic         mul_last;
    logic         in_fire;
    logic         out_free;

    // ------------------------------------------------------------------
    // Configuration port. The user must write only while the unit is idle; the block does not enforce it.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_degree_reg   <= gf2m_pkg::RESET_DEGREE;
            reduction_poly_reg <= gf2m_pkg::RESET_POLY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gf2m_pkg::REG_FIELD_DEGREE:
                    field_degree_reg <= cfg_data[gf2m_pkg::DEG_W-1:0];
                gf2m_pkg::REG_REDUCTION_POLY:
                    reduction_poly_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The degree register is clamped to the range the datapath supports.
    always_comb
    begin
        if (32'(field_degree_reg) < 32'(gf2m_pkg::MIN_DEGREE))
        begin
            m_eff = DW'(gf2m_pkg::MIN_DEGREE);
        end
        else if (32'(field_degree_reg) > 32'(W))
        begin
            m_eff = DW'(W);
        end
        else
        begin
            m_eff = DW'(field_degree_reg);
        end
    end

    // Per-bit masks: elem_mask keeps bits below m, top_mask marks bit m - 1, and the
    // modulus has its x^m term placed by the degree and the rest from the register.
    for (genvar i = 0; i < W; i++)
    begin : g_elem_bit
        assign elem_mask[i] = (DW'(i) < m_eff);
        assign top_mask[i]  = (DW'(i + 1) == m_eff);
        assign modulus[i]   = (DW'(i) == m_eff) | poly_low[i];
        if (i < gf2m_pkg::ELEM_W)
        begin : g_in_range
            assign poly_low[i] = reduction_poly_reg[i] & elem_mask[i];
            assign op_a[i]     = in_data.operand_a[i] & elem_mask[i];
            assign op_b[i]     = in_data.operand_b[i] & elem_mask[i];
        end
        else
        begin : g_above
            assign poly_low[i] = 1'b0;
            assign op_a[i]     = 1'b0;
            assign op_b[i]     = 1'b0;
        end
    end
    assign modulus[W] = (DW'(W) == m_eff);

    for (genvar i = 0; i < gf2m_pkg::ELEM_W; i++)
    begin : g_out_bit
        if (i < W)
        begin : g_in_range
            assign result_elem[i] = acc_reg[i];
            assign result_mask[i] = elem_mask[i];
        end
        else
        begin : g_above
            assign result_elem[i] = 1'b0;
            assign result_mask[i] = 1'b0;
        end
    end

    // One multiplier step, most significant bit of the multiplier first:
    // acc = acc * x mod f, then add the multiplicand when the current bit is set.
    assign acc_top  = |(acc_reg & top_mask);
    assign acc_step = ((acc_reg << 1) & elem_mask)
                    ^ (acc_top ? poly_low : '0)
                    ^ (mul_b_reg[W-1] ? mul_a_reg : '0);

    // The inverter ends when the second remainder is zero. The gcd left in r0 is one
    // exactly when r0 is aligned (top bit set) with a claimed degree of zero.
    assign inv_done = (r1_reg == '0);
    assign inv_ok   = r0_reg[W] && (d0_reg == '0);
    assign mul_last = (cnt_reg == '0);

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Datapath. Operands for every operation are loaded when a beat is taken.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mul_a_reg <= op_a;
                    mul_b_reg <= op_b;
                    acc_reg   <= '0;
                    cnt_reg   <= DW'(W - 1);
                    dz_reg    <= 1'b0;
                    r0_reg    <= modulus;
                    r1_reg    <= {1'b0, op_b};
                    s0_reg    <= '0;
                    s1_reg    <= TW'(1);
                    d0_reg    <= DW'(W);
                    d1_reg    <= DW'(W);
                    case (in_data.kind)
                        gf2m_pkg::KIND_ADD,
                        gf2m_pkg::KIND_SUB:
                            acc_reg <= op_a ^ op_b;
                        gf2m_pkg::KIND_DIV:
                            dz_reg <= (op_b == '0);
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_INV:
            begin
                if (inv_done)
                begin
                    // The inverse is s0 with its scale x^W removed.
                    mul_b_reg <= s0_reg[2*W-1:W];
                end
                else if (!r1_reg[W])
                begin
                    // Align the divisor remainder.
                    r1_reg <= r1_reg << 1;
                    s1_reg <= s1_reg << 1;
                    d1_reg <= d1_reg - 1'b1;
                end
                else if ((r0_reg == '0) || (d0_reg < d1_reg))
                begin
                    // Degree of r0 has dropped below r1, or r0 is zero: next division round.
                    r0_reg <= r1_reg;
                    r1_reg <= r0_reg;
                    s0_reg <= s1_reg;
                    s1_reg <= s0_reg;
                    d0_reg <= d1_reg;
                    d1_reg <= d0_reg;
                end
                else if (!r0_reg[W])
                begin
                    r0_reg <= r0_reg << 1;
                    s0_reg <= s0_reg << 1;
                    d0_reg <= d0_reg - 1'b1;
                end
                else
                begin
                    // Both aligned at the same bit: subtract the shifted divisor.
                    r0_reg <= r0_reg ^ r1_reg;
                    s0_reg <= s0_reg ^ s1_reg;
                end
            end

            S_MUL:
            begin
                acc_reg   <= acc_step;
                mul_b_reg <= mul_b_reg << 1;
                cnt_reg   <= cnt_reg - 1'b1;
            end

            S_DONE:
            begin
            end

            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer and output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (in_data.kind)
                            gf2m_pkg::KIND_MUL:
                                state_reg <= S_MUL;
                            gf2m_pkg::KIND_DIV:
                                state_reg <= (op_b == '0) ? S_DONE : S_INV;
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end

                S_INV:
                begin
                    // A divisor with no inverse leaves a zero result.
                    if (inv_done)
                    begin
                        state_reg <= inv_ok ? S_MUL : S_DONE;
                    end
                end

                S_MUL:
                begin
                    if (mul_last)
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.field_result   <= result_elem;
                        out_data_reg.divide_by_zero <= dz_reg;
                        state_reg                    <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A taken beat always starts work on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != S_IDLE))
    else $error("accepted beat did not leave the idle state");

    // A division by zero delivers a zero element.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.divide_by_zero) |-> (out_data.field_result == '0))
    else $error("divide by zero flagged with a non-zero result");

    // Results never carry coefficients at or above the field degree.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.field_result & ~result_mask) == '0))
    else $error("result has bits at or above the field degree");

endmodule

`default_nettype wire
